// ----- rtl/stack_machine_execute_unit_macros.svh -----
// Assertion macros used by the execute unit controller.
`ifndef STACK_MACHINE_EXECUTE_UNIT_MACROS_SVH
`define STACK_MACHINE_EXECUTE_UNIT_MACROS_SVH
// Implication checked every clock outside reset.
`define SMX_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define SMX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- rtl/smx_pkg.sv -----
// Shared types and constants for the stack machine execute unit.
package smx_pkg;
  localparam int STACK_DEPTH = 2048;
  localparam int CODE_DEPTH  = 512;
  localparam int LEVEL_LIMIT = 3;
  localparam int WORD_BITS   = 32;
  localparam int SA_W = $clog2(STACK_DEPTH);
  localparam int PC_W = $clog2(CODE_DEPTH);
  localparam int DIV_CNT_W = $clog2(WORD_BITS + 1);

  localparam logic [3:0] OP_LIT = 4'd1, OP_OPR = 4'd2, OP_LOD = 4'd3, OP_STO = 4'd4,
                         OP_CAL = 4'd5, OP_INC = 4'd6, OP_JMP = 4'd7, OP_JPC = 4'd8,
                         OP_WRT = 4'd9, OP_RED = 4'd10, OP_HLT = 4'd11;
  localparam logic [15:0] OPR_RET = 16'd0, OPR_NEG = 16'd1, OPR_ADD = 16'd2,
                          OPR_SUB = 16'd3, OPR_MUL = 16'd4, OPR_DIV = 16'd5,
                          OPR_ODD = 16'd6, OPR_MOD = 16'd7, OPR_EQL = 16'd8,
                          OPR_NEQ = 16'd9, OPR_LSS = 16'd10, OPR_LEQ = 16'd11,
                          OPR_GTR = 16'd12, OPR_GEQ = 16'd13;
  localparam logic [1:0] F_NONE = 2'd0, F_DIV0 = 2'd1, F_STACK = 2'd2, F_BAD = 2'd3;

  // Controller to datapath commands.
  typedef struct packed {
    logic       mem_rd;      // read mem at addr
    logic       mem_wr;      // write wval at addr
    logic       ld_a;        // a_r <= rdata
    logic       ld_b;        // b_r <= rdata
    logic       div_start;
  } smx_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic div_done;
  } smx_sts_t;

  function automatic logic in_stack(input logic signed [31:0] a);
    return (a >= 0) && (a < STACK_DEPTH);
  endfunction
  function automatic logic in_code(input logic signed [WORD_BITS:0] a);
    return (a >= 0) && (a < CODE_DEPTH);
  endfunction
endpackage

// ----- rtl/smx_divider.sv -----
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module smx_divider import smx_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [WORD_BITS-1:0] dividend,
  input  logic [WORD_BITS-1:0] divisor,
  output logic                 done,
  output logic [WORD_BITS-1:0] quotient,
  output logic [WORD_BITS-1:0] remainder
);
  logic [WORD_BITS-1:0] q_r, q_nxt, d_r, d_nxt;
  logic [WORD_BITS:0]   rem_r, rem_nxt, trial;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt, qneg_r, qneg_nxt, rneg_r, rneg_nxt;
  logic [WORD_BITS-1:0] ua, ub;

  assign ua = dividend[WORD_BITS-1] ? (~dividend + 1'b1) : dividend;
  assign ub = divisor[WORD_BITS-1] ? (~divisor + 1'b1) : divisor;
  assign trial = {rem_r[WORD_BITS-1:0], q_r[WORD_BITS-1]} - {1'b0, d_r};

  always_comb begin
    q_nxt = q_r; d_nxt = d_r; rem_nxt = rem_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0; qneg_nxt = qneg_r; rneg_nxt = rneg_r;
    if (start) begin
      q_nxt = ua; d_nxt = ub; rem_nxt = '0; cnt_nxt = DIV_CNT_W'(WORD_BITS);
      busy_nxt = 1'b1;
      qneg_nxt = dividend[WORD_BITS-1] ^ divisor[WORD_BITS-1];
      rneg_nxt = dividend[WORD_BITS-1];
    end else if (busy_r) begin
      if (!trial[WORD_BITS]) begin
        rem_nxt = trial;
        q_nxt = {q_r[WORD_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[WORD_BITS-1:0], q_r[WORD_BITS-1]};
        q_nxt = {q_r[WORD_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    q_r <= q_nxt; d_r <= d_nxt; rem_r <= rem_nxt; cnt_r <= cnt_nxt;
    qneg_r <= qneg_nxt; rneg_r <= rneg_nxt;
  end

  assign done = done_r;
  assign quotient = qneg_r ? (~q_r + 1'b1) : q_r;
  assign remainder = rneg_r ? (~rem_r[WORD_BITS-1:0] + 1'b1) : rem_r[WORD_BITS-1:0];
endmodule

// ----- rtl/smx_datapath.sv -----
// Datapath: stack memory, read data register, operand registers and divider.
module smx_datapath import smx_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  smx_cmd_t             cmd,
  input  logic [SA_W-1:0]      addr_in,
  input  logic [WORD_BITS-1:0] wval_in,
  output logic [WORD_BITS-1:0] rdata,
  output logic [WORD_BITS-1:0] a_val,
  output logic [WORD_BITS-1:0] b_val,
  output smx_sts_t             sts,
  output logic [WORD_BITS-1:0] quot,
  output logic [WORD_BITS-1:0] remd
);
  logic [WORD_BITS-1:0] mem [STACK_DEPTH];
  logic [WORD_BITS-1:0] rdata_r, a_r, b_r;

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) mem[addr_in] <= wval_in;
    if (cmd.mem_rd) rdata_r <= mem[addr_in];
    if (cmd.ld_a) a_r <= rdata_r;
    if (cmd.ld_b) b_r <= rdata_r;
  end

  smx_divider u_div (
    .clk, .rst_n, .start(cmd.div_start), .dividend(a_r), .divisor(b_r),
    .done(sts.div_done), .quotient(quot), .remainder(remd)
  );

  assign rdata = rdata_r;
  assign a_val = a_r;
  assign b_val = b_r;
endmodule

// ----- rtl/smx_controller.sv -----
// Controller: instruction sequencing, bounds checks, clearing pass and handshakes.
module smx_controller import smx_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [3:0]           mode,
  input  logic [1:0]           level,
  input  logic [15:0]          operand_m,
  input  logic [31:0]          input_value,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [8:0]           o_pc,
  output logic [10:0]          o_bp,
  output logic [10:0]          o_sp,
  output logic                 o_valid,
  output logic [31:0]          o_value,
  output logic                 o_halted,
  output logic [1:0]           o_fault,
  output smx_cmd_t             cmd,
  output logic [SA_W-1:0]      addr,
  output logic [WORD_BITS-1:0] wval,
  input  logic [WORD_BITS-1:0] rdata,
  input  logic [WORD_BITS-1:0] a_val,
  input  logic [WORD_BITS-1:0] b_val,
  input  smx_sts_t             sts,
  input  logic [WORD_BITS-1:0] quot,
  input  logic [WORD_BITS-1:0] remd
);
  `include "stack_machine_execute_unit_macros.svh"

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_WALK_RD, S_WALK_WT, S_WALK_CHK, S_RD1, S_RD1_WT, S_RD2,
    S_RD2_WT, S_EXEC, S_DIV, S_WR, S_DONE, S_OUT
  } state_t;

  state_t state_r;
  logic [SA_W-1:0] clr_r, sp_r, bp_r, base_r;
  logic [PC_W-1:0] pc_r;
  logic halted_r;
  logic [1:0] fault_r;
  logic [3:0] mode_r;
  logic [1:0] hops_r;
  logic signed [15:0] m_r;
  logic [31:0] inval_r;
  logic [WORD_BITS-1:0] w0_r, w1_r;
  logic [2:0] widx_r, wcnt_r;     // pending writes for CAL
  logic [SA_W-1:0] waddr_r;
  logic [WORD_BITS-1:0] wdat_r;
  logic out_valid_r, emit_r;
  logic [31:0] emit_val_r;

  // Signed views for range checks and comparisons.
  logic signed [31:0] sps, bps, bas, ms;
  logic [PC_W-1:0] seq;
  logic signed [WORD_BITS-1:0] as_, bs_;
  assign sps = 32'(sp_r);
  assign bps = 32'(bp_r);
  assign bas = 32'(base_r);
  assign ms  = 32'(m_r);
  assign seq = pc_r + 1'b1;
  assign as_ = a_val;
  assign bs_ = b_val;

  logic signed [WORD_BITS:0] rsx;
  assign rsx = {rdata[WORD_BITS-1], rdata};
  logic signed [WORD_BITS:0] w0sx;
  assign w0sx = {w0_r[WORD_BITS-1], w0_r};
  logic signed [WORD_BITS:0] w1sx;
  assign w1sx = {w1_r[WORD_BITS-1], w1_r};

  assign in_tready = (state_r == S_IDLE) && !out_valid_r;
  assign out_tvalid = out_valid_r;
  assign o_pc = 9'(pc_r);
  assign o_bp = 11'(bp_r);
  assign o_sp = 11'(sp_r);
  assign o_valid = emit_r;
  assign o_value = emit_r ? emit_val_r : 32'd0;
  assign o_halted = halted_r;
  assign o_fault = fault_r;

  logic is_binop, is_ret;
  assign is_binop = (m_r >= 2) && (m_r <= 13) && (m_r != 6);
  assign is_ret = (mode_r == OP_OPR) && (m_r == $signed(OPR_RET));

  // Operand reads: RET reads bp+2 and bp+3, LOD reads b+m first, others top-1 and top.
  logic [SA_W-1:0] rd1_addr, rd2_addr;
  assign rd1_addr = is_ret ? SA_W'(bp_r + 2'd2) :
                    (mode_r == OP_LOD) ? SA_W'(bas + ms) : SA_W'(sp_r - 1'b1);
  assign rd2_addr = is_ret ? SA_W'(bp_r + 2'd3) : sp_r;

  // Command and address generation.
  always_comb begin
    cmd = '0;
    addr = waddr_r;
    wval = wdat_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.mem_wr = 1'b1; addr = clr_r; wval = '0;
      end
      S_WALK_RD: cmd.mem_rd = 1'b1;
      S_RD1: begin
        cmd.mem_rd = 1'b1; addr = rd1_addr;
      end
      S_RD2: begin
        cmd.mem_rd = 1'b1; addr = rd2_addr;
      end
      S_RD1_WT: cmd.ld_a = 1'b1;
      S_RD2_WT: cmd.ld_b = 1'b1;
      S_EXEC: cmd.div_start = (mode_r == OP_OPR) &&
                              (m_r == $signed(OPR_DIV) || m_r == $signed(OPR_MOD));
      S_WR: cmd.mem_wr = 1'b1;
      default: ;
    endcase
  end

  // Next-state / registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      sp_r <= '0;
      bp_r <= SA_W'(1);
      pc_r <= '0;
      halted_r <= 1'b0;
      fault_r <= F_NONE;
      out_valid_r <= 1'b0;
      emit_r <= 1'b0;
      wcnt_r <= '0;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == SA_W'(STACK_DEPTH - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (out_valid_r && out_tready) out_valid_r <= 1'b0;
          if (in_tvalid && in_tready) begin
            mode_r <= mode; hops_r <= level;
            m_r <= operand_m; inval_r <= input_value;
            base_r <= bp_r; emit_r <= 1'b0; wcnt_r <= '0;
            if (halted_r) state_r <= S_OUT;
            else if ((mode == OP_LOD || mode == OP_STO || mode == OP_CAL) && level != 0)
              state_r <= S_WALK_CHK;
            else state_r <= S_RD1;
          end
        end
        S_WALK_CHK: begin
          if (hops_r == 0) state_r <= S_RD1;
          else if (!in_stack(bas + 1)) begin
            fault_r <= F_STACK; halted_r <= 1'b1; state_r <= S_OUT;
          end else begin
            waddr_r <= SA_W'(base_r + 1'b1); state_r <= S_WALK_RD;
          end
        end
        S_WALK_RD: state_r <= S_WALK_WT;
        S_WALK_WT: begin
          if (rsx < 0 || rsx >= STACK_DEPTH) begin
            fault_r <= F_STACK; halted_r <= 1'b1; state_r <= S_OUT;
          end else begin
            base_r <= SA_W'(rdata); hops_r <= hops_r - 1'b1; state_r <= S_WALK_CHK;
          end
        end
        S_RD1: begin
          // first operand: top-1, bp+2, or b+m
          state_r <= S_RD1_WT;
        end
        S_RD1_WT: begin
          w0_r <= rdata; state_r <= S_RD2;
        end
        S_RD2: state_r <= S_RD2_WT;
        S_RD2_WT: begin
          w1_r <= rdata; state_r <= S_EXEC;
        end
        S_EXEC: begin
          state_r <= S_DONE;
          unique case (mode_r)
            OP_LIT, OP_RED: begin
              if (!in_stack(sps + 1)) begin fault_r <= F_STACK; halted_r <= 1'b1; end
              else begin
                sp_r <= sp_r + 1'b1; pc_r <= seq;
                waddr_r <= sp_r + 1'b1;
                wdat_r <= (mode_r == OP_LIT) ? WORD_BITS'(m_r) : inval_r;
                state_r <= S_WR;
              end
            end
            OP_OPR: begin
              if (m_r == $signed(OPR_RET)) begin
                if (!in_stack(bps - 1) || !in_stack(bps + 3)) begin
                  fault_r <= F_STACK; halted_r <= 1'b1;
                end else if (w0sx < 0 || w0sx >= STACK_DEPTH) begin
                  fault_r <= F_STACK; halted_r <= 1'b1;
                end else if (!in_code(w1sx)) begin
                  fault_r <= F_BAD; halted_r <= 1'b1;
                end else begin
                  sp_r <= bp_r - 1'b1; bp_r <= SA_W'(w0_r); pc_r <= PC_W'(w1_r);
                end
              end else if (m_r == $signed(OPR_NEG) || m_r == $signed(OPR_ODD)) begin
                if (!in_stack(sps)) begin fault_r <= F_STACK; halted_r <= 1'b1; end
                else begin
                  waddr_r <= sp_r; pc_r <= seq; state_r <= S_WR;
                  wdat_r <= (m_r == $signed(OPR_NEG)) ? (~w1_r + 1'b1)
                                                       : WORD_BITS'(w1_r[0]);
                end
              end else if (is_binop) begin
                if (!in_stack(sps) || !in_stack(sps - 1)) begin
                  fault_r <= F_STACK; halted_r <= 1'b1;
                end else if ((m_r == $signed(OPR_DIV) || m_r == $signed(OPR_MOD))) begin
                  if (b_val == '0) begin fault_r <= F_DIV0; halted_r <= 1'b1; end
                  else state_r <= S_DIV;
                end else begin
                  unique case (m_r)
                    $signed(OPR_ADD): wdat_r <= a_val + b_val;
                    $signed(OPR_SUB): wdat_r <= a_val - b_val;
                    $signed(OPR_MUL): wdat_r <= a_val * b_val;
                    $signed(OPR_EQL): wdat_r <= WORD_BITS'(as_ == bs_);
                    $signed(OPR_NEQ): wdat_r <= WORD_BITS'(as_ != bs_);
                    $signed(OPR_LSS): wdat_r <= WORD_BITS'(as_ < bs_);
                    $signed(OPR_LEQ): wdat_r <= WORD_BITS'(as_ <= bs_);
                    $signed(OPR_GTR): wdat_r <= WORD_BITS'(as_ > bs_);
                    default:          wdat_r <= WORD_BITS'(as_ >= bs_);
                  endcase
                  waddr_r <= sp_r - 1'b1; sp_r <= sp_r - 1'b1; pc_r <= seq;
                  state_r <= S_WR;
                end
              end else begin
                fault_r <= F_BAD; halted_r <= 1'b1;
              end
            end
            OP_LOD: begin
              if (!in_stack(bas + ms) || !in_stack(sps + 1)) begin
                fault_r <= F_STACK; halted_r <= 1'b1;
              end else begin
                waddr_r <= sp_r + 1'b1; wdat_r <= w0_r;
                sp_r <= sp_r + 1'b1; pc_r <= seq; state_r <= S_WR;
              end
            end
            OP_STO: begin
              if (!in_stack(bas + ms) || !in_stack(sps) || !in_stack(sps - 1)) begin
                fault_r <= F_STACK; halted_r <= 1'b1;
              end else begin
                waddr_r <= SA_W'(bas + ms); wdat_r <= w1_r;
                sp_r <= sp_r - 1'b1; pc_r <= seq; state_r <= S_WR;
              end
            end
            OP_CAL: begin
              if (!in_stack(sps + 1) || !in_stack(sps + 4)) begin
                fault_r <= F_STACK; halted_r <= 1'b1;
              end else if (m_r < 0 || ms >= CODE_DEPTH) begin
                fault_r <= F_BAD; halted_r <= 1'b1;
              end else begin
                // old frame base and return address are held for the later writes
                waddr_r <= sp_r + 1'b1; wdat_r <= '0; widx_r <= 3'd1; wcnt_r <= 3'd3;
                w0_r <= WORD_BITS'(bp_r); w1_r <= WORD_BITS'(seq);
                bp_r <= sp_r + 1'b1; pc_r <= PC_W'(m_r); state_r <= S_WR;
              end
            end
            OP_INC: begin
              if (!in_stack(sps + ms)) begin fault_r <= F_STACK; halted_r <= 1'b1; end
              else begin sp_r <= SA_W'(sps + ms); pc_r <= seq; end
            end
            OP_JMP: begin
              if (m_r < 0 || ms >= CODE_DEPTH) begin fault_r <= F_BAD; halted_r <= 1'b1; end
              else pc_r <= PC_W'(m_r);
            end
            OP_JPC: begin
              if (!in_stack(sps) || !in_stack(sps - 1)) begin
                fault_r <= F_STACK; halted_r <= 1'b1;
              end else if (w1_r == '0) begin
                if (m_r < 0 || ms >= CODE_DEPTH) begin fault_r <= F_BAD; halted_r <= 1'b1; end
                else begin pc_r <= PC_W'(m_r); sp_r <= sp_r - 1'b1; end
              end else begin
                pc_r <= seq; sp_r <= sp_r - 1'b1;
              end
            end
            OP_WRT: begin
              if (!in_stack(sps) || !in_stack(sps - 1)) begin
                fault_r <= F_STACK; halted_r <= 1'b1;
              end else begin
                emit_r <= 1'b1; emit_val_r <= w1_r;
                sp_r <= sp_r - 1'b1; pc_r <= seq;
              end
            end
            OP_HLT: begin
              halted_r <= 1'b1; pc_r <= seq;
            end
            default: begin
              fault_r <= F_BAD; halted_r <= 1'b1;
            end
          endcase
        end
        S_DIV: begin
          if (sts.div_done) begin
            if (m_r == $signed(OPR_DIV))
              wdat_r <= (b_val == '1) ? (~a_val + 1'b1) : quot;
            else
              wdat_r <= (b_val == '1) ? '0 : remd;
            waddr_r <= sp_r - 1'b1; sp_r <= sp_r - 1'b1; pc_r <= seq;
            state_r <= S_WR;
          end
        end
        S_WR: begin
          if (wcnt_r != 0) begin
            wcnt_r <= wcnt_r - 1'b1;
            widx_r <= widx_r + 1'b1;
            waddr_r <= waddr_r + 1'b1;
            unique case (widx_r)
              3'd1: wdat_r <= WORD_BITS'(base_r);
              3'd2: wdat_r <= w0_r;
              default: wdat_r <= w1_r;
            endcase
          end else state_r <= S_DONE;
        end
        S_DONE, S_OUT: begin
          out_valid_r <= 1'b1; state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `SMX_ASSERT_IMP(a_ready_idle, in_tready, state_r == S_IDLE, "ready outside idle")
  `SMX_ASSERT_NEXT(a_fault_halts, fault_r == F_NONE && state_r == S_EXEC && mode_r > OP_HLT,
                   halted_r, "bad opcode did not halt")
  `SMX_ASSERT_IMP(a_emit_valid, out_tvalid && o_valid, !halted_r || fault_r == F_NONE,
                  "write emitted by faulted machine")
endmodule

// ----- rtl/stack_machine_execute_unit.sv -----
// From input transfer to out_tvalid: optional static link walk, RD1, RD1_WT, RD2, RD2_WT,
// EXEC, S_DIV for DIV/MOD, S_WR for a stack write (four words for CAL), then DONE; a stopped
// machine goes straight to S_OUT. Each link level takes WALK_CHK, WALK_RD and WALK_WT on the
// single memory port, and a last WALK_CHK ends the walk. One instruction in flight; the next
// is accepted the cycle after the result transfer. Reset is synchronous, active low; a
// clearing pass over all STACK_DEPTH (2048) words zeroes the stack memory after reset, with in_tready low meanwhile.
module stack_machine_execute_unit import smx_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // mode[3:0], level[5:4], operand_m[21:6], input_value[53:22]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // next_pc[8:0], base_pointer[19:9], stack_pointer[30:20],
                                  // out_valid[31], out_value[63:32]
  output logic [2:0]  out_tuser   // halted[0], fault[2:1]
);
  smx_cmd_t cmd;
  smx_sts_t sts;
  logic [SA_W-1:0] addr;
  logic [WORD_BITS-1:0] wval, rdata, a_val, b_val, quot, remd;
  logic [8:0] o_pc;
  logic [10:0] o_bp, o_sp;
  logic o_valid, o_halted;
  logic [31:0] o_value;
  logic [1:0] o_fault;

  smx_controller u_ctl (
    .clk, .rst_n, .in_tvalid, .in_tready,
    .mode(in_tdata[3:0]), .level(in_tdata[5:4]), .operand_m(in_tdata[21:6]),
    .input_value(in_tdata[53:22]), .out_tvalid, .out_tready,
    .o_pc, .o_bp, .o_sp, .o_valid, .o_value, .o_halted, .o_fault,
    .cmd, .addr, .wval, .rdata, .a_val, .b_val, .sts, .quot, .remd
  );

  smx_datapath u_dp (
    .clk, .rst_n, .cmd, .addr_in(addr), .wval_in(wval), .rdata, .a_val, .b_val,
    .sts, .quot, .remd
  );

  assign out_tdata = {o_value, o_valid, o_sp, o_bp, o_pc};
  assign out_tuser = {o_fault, o_halted};
endmodule
